### rtl/core/ilid_pkg.sv
// Shared types, codes and constants for the indexed list store.
package ilid_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int DATA_W           = 32;
  localparam int IDX_W            = 16;
  localparam int OP_W             = 3;
  localparam int ST_W             = 2;
  localparam int MAX_POS_W        = 10;
  localparam int GROUP_SIZE       = 32;

  localparam logic [OP_W-1:0] OP_READ        = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT_HEAD = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT_AT   = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE      = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_READ,
    ACT_INSERT,
    ACT_DELETE
  } act_e;

  typedef struct packed {
    act_e                 act;
    logic [MAX_POS_W-1:0] pos;
    logic [DATA_W-1:0]    value;
  } cmd_t;

endpackage

### rtl/core/ilid_cell.sv
// One storage cell of the list chain: holds one value and shifts with its neighbors.
module ilid_cell (
  input  logic                          clk_i,
  input  ilid_pkg::cmd_t                cmd_i,
  input  logic [ilid_pkg::MAX_POS_W-1:0] cell_idx_i,
  input  logic [ilid_pkg::DATA_W-1:0]   left_i,
  input  logic [ilid_pkg::DATA_W-1:0]   right_i,
  output logic [ilid_pkg::DATA_W-1:0]   data_o,
  output logic [ilid_pkg::DATA_W-1:0]   rd_o
);

  logic [ilid_pkg::DATA_W-1:0] data_q;
  logic [ilid_pkg::DATA_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i.act)
      ilid_pkg::ACT_INSERT: begin
        if (cell_idx_i > cmd_i.pos) begin
          data_d = left_i;
        end else if (cell_idx_i == cmd_i.pos) begin
          data_d = cmd_i.value;
        end
      end
      ilid_pkg::ACT_DELETE: begin
        if (cell_idx_i >= cmd_i.pos) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (cmd_i.act == ilid_pkg::ACT_READ && cell_idx_i == cmd_i.pos) ?
                  data_q : '0;

endmodule

### rtl/core/indexed_list_insert_delete_top.sv
// Top level of the indexed list store: command decode, cell chain and read gather.
// A transaction accepted at one edge is presented on done_o once it has passed s1_q,
// s2_q and done_q. No new transaction is taken while busy_o is high; busy_o covers the cell update and
// the two registered levels of the read gather tree.
// Reset clears the length, the handshake strobes and the latched command; stored values stay undefined until written.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module indexed_list_insert_delete_top #(
  parameter int CAPACITY = ilid_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [ilid_pkg::OP_W-1:0]           op_i,
  input  logic signed [ilid_pkg::IDX_W-1:0]   index_i,
  input  logic signed [ilid_pkg::DATA_W-1:0]  value_i,
  output logic                                done_o,
  output logic signed [ilid_pkg::DATA_W-1:0]  read_value_o,
  output logic [ilid_pkg::ST_W-1:0]           status_o,
  output logic [$clog2(CAPACITY+1)-1:0]       length_o
);

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int GROUPS = (CAPACITY + ilid_pkg::GROUP_SIZE - 1) / ilid_pkg::GROUP_SIZE;
  localparam int MW     = ilid_pkg::IDX_W - 1;

  logic [CW-1:0]               count_q, count_d;
  logic                        s1_q, s2_q, done_q;
  ilid_pkg::cmd_t              cmd_q, cmd_d;
  logic [ilid_pkg::ST_W-1:0]   st_q, st_d;
  logic                        is_read_q, is_read2_q;
  logic [ilid_pkg::DATA_W-1:0] rd_q;
  logic [ilid_pkg::DATA_W-1:0] grp_q [GROUPS];
  logic [ilid_pkg::DATA_W-1:0] grp_d [GROUPS];
  logic [ilid_pkg::DATA_W-1:0] gather;
  logic [ilid_pkg::DATA_W-1:0] cell_data [CAPACITY];
  logic [ilid_pkg::DATA_W-1:0] cell_rd   [CAPACITY];
  logic                        accept;
  logic                        full;
  logic                        idx_neg;
  logic [MW-1:0]               idx_mag;
  logic [MW-1:0]               count_x;

  assign accept  = start_i && !busy_o;
  assign full    = (count_q == CW'(CAPACITY));
  assign idx_neg = index_i[ilid_pkg::IDX_W-1];
  assign idx_mag = index_i[MW-1:0];
  assign count_x = MW'(count_q);

  always_comb begin
    cmd_d       = '0;
    cmd_d.act   = ilid_pkg::ACT_NONE;
    cmd_d.value = value_i;
    st_d        = ilid_pkg::ST_DONE;
    count_d     = count_q;
    case (op_i)
      ilid_pkg::OP_READ: begin
        if (idx_neg || idx_mag >= count_x) begin
          st_d = ilid_pkg::ST_BAD_INDEX;
        end else begin
          cmd_d.act = ilid_pkg::ACT_READ;
          cmd_d.pos = ilid_pkg::MAX_POS_W'(idx_mag);
        end
      end
      ilid_pkg::OP_INSERT_HEAD: begin
        if (full) begin
          st_d = ilid_pkg::ST_FULL;
        end else begin
          cmd_d.act = ilid_pkg::ACT_INSERT;
          count_d   = count_q + CW'(1);
        end
      end
      ilid_pkg::OP_INSERT_TAIL: begin
        if (full) begin
          st_d = ilid_pkg::ST_FULL;
        end else begin
          cmd_d.act = ilid_pkg::ACT_INSERT;
          cmd_d.pos = ilid_pkg::MAX_POS_W'(count_q);
          count_d   = count_q + CW'(1);
        end
      end
      ilid_pkg::OP_INSERT_AT: begin
        if (!idx_neg && idx_mag > count_x) begin
          st_d = ilid_pkg::ST_BAD_INDEX;
        end else if (full) begin
          st_d = ilid_pkg::ST_FULL;
        end else begin
          cmd_d.act = ilid_pkg::ACT_INSERT;
          cmd_d.pos = idx_neg ? '0 : ilid_pkg::MAX_POS_W'(idx_mag);
          count_d   = count_q + CW'(1);
        end
      end
      ilid_pkg::OP_DELETE: begin
        if (idx_neg || idx_mag >= count_x) begin
          st_d = ilid_pkg::ST_BAD_INDEX;
        end else begin
          cmd_d.act = ilid_pkg::ACT_DELETE;
          cmd_d.pos = ilid_pkg::MAX_POS_W'(idx_mag);
          count_d   = count_q - CW'(1);
        end
      end
      default: st_d = ilid_pkg::ST_BAD_INDEX;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      s1_q    <= 1'b0;
      s2_q    <= 1'b0;
      done_q  <= 1'b0;
      cmd_q   <= '0;
    end else begin
      s1_q   <= accept;
      s2_q   <= s1_q;
      done_q <= s2_q;
      if (accept) begin
        count_q <= count_d;
        cmd_q   <= cmd_d;
      end else begin
        cmd_q.act <= ilid_pkg::ACT_NONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q      <= st_d;
      is_read_q <= (cmd_d.act == ilid_pkg::ACT_READ);
    end
    is_read2_q <= is_read_q;
    grp_q      <= grp_d;
    rd_q       <= is_read2_q ? gather : '1;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ilid_pkg::DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    ilid_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd_q),
      .cell_idx_i (ilid_pkg::MAX_POS_W'(i)),
      .left_i     (left),
      .right_i    (right),
      .data_o     (cell_data[i]),
      .rd_o       (cell_rd[i])
    );
  end

  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    always_comb begin
      grp_d[g] = '0;
      for (int k = 0; k < ilid_pkg::GROUP_SIZE; k++) begin
        if (g * ilid_pkg::GROUP_SIZE + k < CAPACITY) begin
          grp_d[g] = grp_d[g] | cell_rd[g * ilid_pkg::GROUP_SIZE + k];
        end
      end
    end
  end

  always_comb begin
    gather = '0;
    for (int g = 0; g < GROUPS; g++) begin
      gather = gather | grp_q[g];
    end
  end

  assign busy_o       = s1_q || s2_q;
  assign done_o       = done_q;
  assign read_value_o = rd_q;
  assign status_o     = st_q;
  assign length_o     = count_q;

endmodule

### rtl/core/ilid_checker.sv
// Port-level checks for the indexed list store and their binding to the top level.
module ilid_checker #(
  parameter int CAPACITY = ilid_pkg::DEFAULT_CAPACITY
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start_i,
  input logic                                busy_i,
  input logic                                done_i,
  input logic [ilid_pkg::ST_W-1:0]           status_i,
  input logic [$clog2(CAPACITY+1)-1:0]       length_i
);

  localparam int CW = $clog2(CAPACITY + 1);

  a_done_three_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |-> ##3 done_i)
    else $error("Result strobe did not follow an accepted transaction.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> busy_i)
    else $error("Busy did not rise after an accepted transaction.");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy_i)
    else $error("Result strobe came while the block was busy.");

  a_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && status_i == ilid_pkg::ST_FULL |-> length_i == CW'(CAPACITY))
    else $error("Full status reported while the store was not full.");

  a_length_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> length_i <= CW'(CAPACITY))
    else $error("Length exceeds capacity.");

endmodule

bind indexed_list_insert_delete_top ilid_checker #(.CAPACITY(CAPACITY)) u_ilid_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_i   (busy_o),
  .done_i   (done_o),
  .status_i (status_o),
  .length_i (length_o)
);
